>>> hw/rtl/tass_pkg.sv
// tass_pkg: types, codes and constants for the three-axis stepper sequencer
// no dependencies; used by the lanes, merge stage, top level and testbench

package tass_pkg;

  localparam int NMOT = 3;

  localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] POS_MIN = -24'sh800000;

  localparam logic [15:0] DELAY_RESET [8] = '{
    16'd200, 16'd36000, 16'd24000, 16'd18000,
    16'd12000, 16'd6000, 16'd3200, 16'd1600
  };

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_SET_SPEED  = 3'd1,
    ACT_STEP_MOVE  = 3'd2,
    ACT_POWER_ON   = 3'd3,
    ACT_POWER_OFF  = 3'd4
  } action_t;

  // decoded item as seen by every lane
  typedef struct packed {
    logic [2:0]        action;
    logic [1:0]        motor;
    logic signed [3:0] speed;
    logic [13:0]       steps;
    logic [15:0]       elapsed;
    logic [15:0]       reload_sel;
    logic [15:0]       delay0;
  } cmd_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  idx;
    logic [15:0] data;
  } cfg_t;

  typedef struct packed {
    logic [3:0]        coils;
    logic signed [23:0] pos;
    logic              done;
  } lane_out_t;

  typedef struct packed {
    logic [3:0]        coils_pan;
    logic [3:0]        coils_tilt;
    logic [3:0]        coils_rotate;
    logic signed [23:0] pos_pan;
    logic signed [23:0] pos_tilt;
    logic signed [23:0] pos_rotate;
    logic [2:0]        move_done;
  } result_t;

  // wave drive: phase 0 IN1, phase 1 IN3, phase 2 IN2, phase 3 IN4
  function automatic logic [3:0] phase_pattern(input logic [1:0] ph);
    logic [3:0] p;
    case (ph)
      2'd0:    p = 4'b0001;
      2'd1:    p = 4'b0100;
      2'd2:    p = 4'b0010;
      default: p = 4'b1000;
    endcase
    return p;
  endfunction

endpackage

>>> hw/rtl/tass_if.sv
// tass channel interfaces: command input, result output, configuration write
// depends on nothing; payload widths follow the block's item fields, but for the byte-wide speed

interface tass_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [1:0]        motor;
  logic signed [7:0] speed;
  logic [13:0]       steps;
  logic [15:0]       elapsed_us;

  modport source (output valid, action, motor, speed, steps, elapsed_us, input ready);
  modport sink   (input valid, action, motor, speed, steps, elapsed_us, output ready);
endinterface

interface tass_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         coils_pan;
  logic [3:0]         coils_tilt;
  logic [3:0]         coils_rotate;
  logic signed [23:0] pos_pan;
  logic signed [23:0] pos_tilt;
  logic signed [23:0] pos_rotate;
  logic [2:0]         move_done;

  modport source (output valid, coils_pan, coils_tilt, coils_rotate, pos_pan, pos_tilt,
                  pos_rotate, move_done, input ready);
  modport sink   (input valid, coils_pan, coils_tilt, coils_rotate, pos_pan, pos_tilt,
                  pos_rotate, move_done, output ready);
endinterface

interface tass_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/tass_lane.sv
// tass_lane: state and per-item update of a single stepper motor
// depends on tass_pkg (cmd_t, cfg_t, lane_out_t, action codes, phase_pattern, POS_MAX/POS_MIN, DELAY_RESET)

module tass_lane #(
  parameter int IDLE_DUTY_DIVISOR = 3,
  parameter int LANE = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  tass_pkg::cmd_t      cmd,
  input  tass_pkg::cfg_t      cfg,
  output tass_pkg::lane_out_t lane_out
);

  localparam int IW = (IDLE_DUTY_DIVISOR > 1) ? $clog2(IDLE_DUTY_DIVISOR) : 1;

  logic [15:0]        countdown, countdown_next;
  logic signed [3:0]  speed, speed_next;
  logic [1:0]         phase, phase_next;
  logic [13:0]        budget, budget_next;
  logic signed [23:0] pos, pos_next;
  logic [IW-1:0]      idle, idle_next;
  logic               powered, powered_next;
  logic [3:0]         latch, latch_next;
  logic [15:0]        reload, reload_next;   // delay for the current speed magnitude

  logic [3:0]  speed_neg;
  logic [2:0]  mag;
  logic [IW:0] idle_inc;
  logic        blank;
  logic        done;
  logic        sel;

  assign speed_neg = -speed;
  assign mag       = speed[3] ? speed_neg[2:0] : speed[2:0];
  assign idle_inc  = {1'b0, idle} + 1'b1;
  assign sel       = (cmd.motor == 2'(LANE));

  always_comb begin
    countdown_next = countdown;
    speed_next     = speed;
    phase_next     = phase;
    budget_next    = budget;
    pos_next       = pos;
    idle_next      = idle;
    powered_next   = powered;
    latch_next     = latch;
    reload_next    = reload;
    blank          = 1'b0;
    done           = 1'b0;
    case (cmd.action)
      tass_pkg::ACT_TICK: begin
        if (countdown > cmd.elapsed) begin
          countdown_next = countdown - cmd.elapsed;
        end else begin
          countdown_next = reload;
          if (speed > 4'sd0) begin
            phase_next = phase + 2'd1;
          end else if (speed < 4'sd0) begin
            phase_next = phase - 2'd1;
          end else begin
            blank     = (idle == '0);
            idle_next = (idle_inc >= (IW+1)'(IDLE_DUTY_DIVISOR)) ? '0 : idle_inc[IW-1:0];
          end
          latch_next = (powered && !blank) ? tass_pkg::phase_pattern(phase_next) : 4'd0;
          if (speed != 4'sd0) begin
            if (speed > 4'sd0) begin
              if (pos != tass_pkg::POS_MAX) pos_next = pos + 24'sd1;
            end else begin
              if (pos != tass_pkg::POS_MIN) pos_next = pos - 24'sd1;
            end
            if (budget != 14'd0) begin
              budget_next = budget - 14'd1;
              if (budget == 14'd1) begin
                speed_next  = 4'sd0;
                reload_next = cmd.delay0;
                done        = 1'b1;
              end
            end
          end
        end
      end
      tass_pkg::ACT_SET_SPEED: begin
        if (sel) begin
          if (cmd.speed == 4'sd0) begin
            budget_next = 14'd1;
          end else begin
            speed_next  = cmd.speed;
            reload_next = cmd.reload_sel;
          end
        end
      end
      tass_pkg::ACT_STEP_MOVE: begin
        if (sel) begin
          budget_next = cmd.steps;
          speed_next  = cmd.speed;
          reload_next = cmd.reload_sel;
        end
      end
      tass_pkg::ACT_POWER_ON:  powered_next = 1'b1;
      tass_pkg::ACT_POWER_OFF: powered_next = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown <= '0;
      speed     <= '0;
      phase     <= '0;
      budget    <= '0;
      pos       <= '0;
      idle      <= '0;
      powered   <= 1'b0;
      latch     <= '0;
      reload    <= tass_pkg::DELAY_RESET[0];
    end else if (accept) begin
      countdown <= countdown_next;
      speed     <= speed_next;
      phase     <= phase_next;
      budget    <= budget_next;
      pos       <= pos_next;
      idle      <= idle_next;
      powered   <= powered_next;
      latch     <= latch_next;
      reload    <= reload_next;
    end else if (cfg.we && cfg.idx == mag) begin
      // keep the cached reload in step with its delay register
      reload <= cfg.data;
    end
  end

  assign lane_out.coils = powered_next ? latch_next : 4'd0;
  assign lane_out.pos   = pos_next;
  assign lane_out.done  = done;

endmodule

>>> hw/rtl/tass_merge.sv
// tass_merge: gathers the lane results into one beat, with output and skid registers
// depends on tass_pkg (lane_out_t, result_t, NMOT)

module tass_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tass_pkg::lane_out_t lanes [tass_pkg::NMOT],
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tass_pkg::result_t   out_data
);

  tass_pkg::result_t merged;
  tass_pkg::result_t main_q, skid_q;
  logic              main_valid, skid_valid;
  logic              pop;

  always_comb begin
    merged.coils_pan    = lanes[0].coils;
    merged.coils_tilt   = lanes[1].coils;
    merged.coils_rotate = lanes[2].coils;
    merged.pos_pan      = lanes[0].pos;
    merged.pos_tilt     = lanes[1].pos;
    merged.pos_rotate   = lanes[2].pos;
    merged.move_done    = {lanes[2].done, lanes[1].done, lanes[0].done};
  end

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_q;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_q     <= skid_q;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_q <= merged;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_q     <= merged;
        skid_valid <= 1'b1;
      end else begin
        main_q     <= merged;
        main_valid <= 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/three_axis_stepper_sequencer.sv
// three_axis_stepper_sequencer: top level, delay registers, lanes and merge stage
// depends on tass_pkg, tass_if, tass_lane, tass_merge
//
//   channel   dir   handshake        payload
//   in_ch     in    valid / ready    action, motor, speed, steps, elapsed_us
//   out_ch    out   valid / ready    coils_*, pos_*, move_done
//   cfg       in    valid / ready    index (delay_speed_0..7), data
//
// for each item the per-motor lanes update side by side and the
// merge stage registers the result beat, one result per item
// a skid register lets one more item in while a result waits, so a new item
// can enter every cycle as long as out_ch drains
// synchronous active-high reset: motors stopped, unpowered, at home, delays at defaults
// cfg is always ready; writes are expected only while the block is idle

module three_axis_stepper_sequencer #(
  parameter int IDLE_DUTY_DIVISOR = 3,
  parameter int MOTOR_COUNT = 3
) (
  input logic       clk,
  input logic       rst,
  tass_in_if.sink   in_ch,
  tass_out_if.source out_ch,
  tass_cfg_if.sink  cfg
);

  // delay registers, one per speed magnitude
  logic [15:0] delay_reg [8];

  tass_pkg::cmd_t      cmd;
  tass_pkg::cfg_t      cfg_w;
  tass_pkg::lane_out_t lanes [tass_pkg::NMOT];
  tass_pkg::result_t   result;

  logic              accept;
  logic              in_ready;
  logic signed [3:0] sp_sat;
  logic [3:0]        sp_neg;
  logic [2:0]        sp_mag;

  assign cfg.ready = 1'b1;
  assign cfg_w.we   = cfg.valid;
  assign cfg_w.idx  = cfg.index;
  assign cfg_w.data = cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) delay_reg[i] <= tass_pkg::DELAY_RESET[i];
    end else if (cfg.valid) begin
      delay_reg[cfg.index] <= cfg.data;
    end
  end

  // speed request saturates to plus or minus seven
  always_comb begin
    if (in_ch.speed > 8'sd7) begin
      sp_sat = 4'sd7;
    end else if (in_ch.speed < -8'sd7) begin
      sp_sat = -4'sd7;
    end else begin
      sp_sat = in_ch.speed[3:0];
    end
  end

  assign sp_neg = -sp_sat;
  assign sp_mag = sp_sat[3] ? sp_neg[2:0] : sp_sat[2:0];

  assign cmd.action     = in_ch.action;
  assign cmd.motor      = in_ch.motor;
  assign cmd.speed      = sp_sat;
  assign cmd.steps      = in_ch.steps;
  assign cmd.elapsed    = in_ch.elapsed_us;
  assign cmd.reload_sel = delay_reg[sp_mag];
  assign cmd.delay0     = delay_reg[0];

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  // one lane per fitted motor; absent motors read zero
  for (genvar g = 0; g < tass_pkg::NMOT; g++) begin : g_lane
    if (g < MOTOR_COUNT) begin : g_on
      tass_lane #(
        .IDLE_DUTY_DIVISOR(IDLE_DUTY_DIVISOR),
        .LANE(g)
      ) u_lane (
        .clk     (clk),
        .rst     (rst),
        .accept  (accept),
        .cmd     (cmd),
        .cfg     (cfg_w),
        .lane_out(lanes[g])
      );
    end else begin : g_off
      assign lanes[g] = '0;
    end
  end

  tass_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .lanes    (lanes),
    .in_ready (in_ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data (result)
  );

  assign out_ch.coils_pan    = result.coils_pan;
  assign out_ch.coils_tilt   = result.coils_tilt;
  assign out_ch.coils_rotate = result.coils_rotate;
  assign out_ch.pos_pan      = result.pos_pan;
  assign out_ch.pos_tilt     = result.pos_tilt;
  assign out_ch.pos_rotate   = result.pos_rotate;
  assign out_ch.move_done    = result.move_done;

endmodule

>>> bench/tb_three_axis_stepper_sequencer.sv
// testbench for three_axis_stepper_sequencer: directed and random commands and ticks,
// every result beat checked against an in-bench motion model of the three motors
// depends on tass_pkg, tass_if and the rtl of the sequencer
`timescale 1ns / 1ps

module tb_three_axis_stepper_sequencer;

  localparam int IDLE_DIVISOR = 3;
  localparam int DELAY_REGS = 8;

  // motor selects, the last one is out of range on purpose
  localparam logic [1:0] AXIS_PAN = 2'd0;
  localparam logic [1:0] AXIS_TILT = 2'd1;
  localparam logic [1:0] AXIS_ROTATE = 2'd2;
  localparam logic [1:0] AXIS_BAD = 2'd3;

  // one command beat as the sender drives it
  typedef struct {
    logic [2:0]        action;
    logic [1:0]        motor;
    logic signed [7:0] speed;
    logic [13:0]       steps;
    logic [15:0]       elapsed;
  } cmd_beat_t;

  // motion model of the three motors plus the queue of coil/position frames it predicts
  class stepper_scoreboard;
    logic [15:0] delay_us [DELAY_REGS];
    logic [15:0] countdown [tass_pkg::NMOT];
    int          speed_now [tass_pkg::NMOT];
    logic [1:0]  phase [tass_pkg::NMOT];
    logic [13:0] budget [tass_pkg::NMOT];
    int          pos [tass_pkg::NMOT];
    int          idle_cnt [tass_pkg::NMOT];
    bit          powered [tass_pkg::NMOT];
    logic [3:0]  latch [tass_pkg::NMOT];
    logic [3:0]  wave_coil [4];
    tass_pkg::result_t coil_pos_frames [$];
    int          errors;

    function new();
      // one coil at a time: IN1, IN3, IN2, IN4
      wave_coil = '{4'b0001, 4'b0100, 4'b0010, 4'b1000};
      foreach (delay_us[i]) delay_us[i] = tass_pkg::DELAY_RESET[i];
      foreach (countdown[m]) begin
        countdown[m] = '0;
        speed_now[m] = 0;
        phase[m] = '0;
        budget[m] = '0;
        pos[m] = 0;
        idle_cnt[m] = 0;
        powered[m] = 1'b0;
        latch[m] = '0;
      end
      errors = 0;
    endfunction

    function void set_delay(int idx, logic [15:0] val);
      delay_us[idx] = val;
    endfunction

    function int pending();
      return coil_pos_frames.size();
    endfunction

    // one motor on one tick; returns 1 when its step budget ran out
    function bit step_timer(int m, logic [15:0] el);
      int sp;
      int mag;
      bit blank;
      sp = speed_now[m];
      mag = (sp < 0) ? -sp : sp;
      blank = 1'b0;
      if (countdown[m] > el) begin
        countdown[m] = countdown[m] - el;
        return 1'b0;
      end
      // expiry: reload, surplus time is dropped
      countdown[m] = delay_us[mag];
      if (sp > 0) begin
        phase[m] = phase[m] + 2'd1;
      end else if (sp < 0) begin
        phase[m] = phase[m] - 2'd1;
      end else begin
        if (idle_cnt[m] == 0) blank = 1'b1;
        idle_cnt[m] = (idle_cnt[m] + 1 >= IDLE_DIVISOR) ? 0 : idle_cnt[m] + 1;
      end
      latch[m] = (powered[m] && !blank) ? wave_coil[phase[m]] : 4'b0000;
      if (sp != 0) begin
        if (sp > 0) begin
          if (pos[m] < int'(tass_pkg::POS_MAX)) pos[m]++;
        end else begin
          if (pos[m] > int'(tass_pkg::POS_MIN)) pos[m]--;
        end
        if (budget[m] != 0) begin
          budget[m]--;
          if (budget[m] == 0) begin
            speed_now[m] = 0;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    // accepted command beat: advance the model and queue the frame it yields
    function void note_cmd(cmd_beat_t c);
      int sp;
      logic [2:0] done;
      tass_pkg::result_t r;
      sp = c.speed;
      if (sp > 7) sp = 7;
      if (sp < -7) sp = -7;
      done = '0;
      case (c.action)
        tass_pkg::ACT_TICK: begin
          for (int m = 0; m < tass_pkg::NMOT; m++) done[m] = step_timer(m, c.elapsed);
        end
        tass_pkg::ACT_SET_SPEED: begin
          if (c.motor < tass_pkg::NMOT) begin
            if (sp == 0) budget[c.motor] = 14'd1;
            else speed_now[c.motor] = sp;
          end
        end
        tass_pkg::ACT_STEP_MOVE: begin
          if (c.motor < tass_pkg::NMOT) begin
            budget[c.motor] = c.steps;
            speed_now[c.motor] = sp;
          end
        end
        tass_pkg::ACT_POWER_ON: begin
          foreach (powered[m]) powered[m] = 1'b1;
        end
        tass_pkg::ACT_POWER_OFF: begin
          foreach (powered[m]) powered[m] = 1'b0;
        end
        default: ;
      endcase
      r.coils_pan = powered[0] ? latch[0] : 4'b0000;
      r.coils_tilt = powered[1] ? latch[1] : 4'b0000;
      r.coils_rotate = powered[2] ? latch[2] : 4'b0000;
      r.pos_pan = 24'(pos[0]);
      r.pos_tilt = 24'(pos[1]);
      r.pos_rotate = 24'(pos[2]);
      r.move_done = done;
      coil_pos_frames.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_state(tass_pkg::result_t got);
      tass_pkg::result_t want;
      logic [3:0] gc [3];
      logic [3:0] wc [3];
      logic [23:0] gp [3];
      logic [23:0] wp [3];
      string axis [3];
      axis = '{"pan", "tilt", "rotate"};
      if (coil_pos_frames.size() == 0) begin
        report("result beat with no command pending");
        return;
      end
      want = coil_pos_frames.pop_front();
      gc = '{got.coils_pan, got.coils_tilt, got.coils_rotate};
      wc = '{want.coils_pan, want.coils_tilt, want.coils_rotate};
      gp = '{got.pos_pan, got.pos_tilt, got.pos_rotate};
      wp = '{want.pos_pan, want.pos_tilt, want.pos_rotate};
      for (int m = 0; m < 3; m++) begin
        if (gc[m] !== wc[m])
          report($sformatf("coils_%s got %h want %h", axis[m], gc[m], wc[m]));
        if (gp[m] !== wp[m])
          report($sformatf("pos_%s got %0d want %0d", axis[m],
                           $signed(gp[m]), $signed(wp[m])));
      end
      if (got.move_done !== want.move_done)
        report($sformatf("move_done got %b want %b", got.move_done, want.move_done));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int   src_idle_pct;
  int   sink_stall_pct;

  tass_in_if  in_ch ();
  tass_out_if out_ch ();
  tass_cfg_if cfg_ch ();

  stepper_scoreboard sb = new();

  three_axis_stepper_sequencer #(
    .IDLE_DUTY_DIVISOR(IDLE_DIVISOR),
    .MOTOR_COUNT(tass_pkg::NMOT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg_ch)
  );

  always #10 clk = ~clk;

  function automatic cmd_beat_t beat_of(logic [2:0] act, logic [1:0] mot,
                                        logic signed [7:0] spd, logic [13:0] stp,
                                        logic [15:0] el);
    cmd_beat_t c;
    c.action = act;
    c.motor = mot;
    c.speed = spd;
    c.steps = stp;
    c.elapsed = el;
    return c;
  endfunction

  // mostly within plus or minus seven, now and then anything the byte holds
  function automatic logic signed [7:0] rand_speed();
    if ($urandom_range(99) < 85) return 8'($signed($urandom_range(0, 14)) - 7);
    return 8'($urandom_range(0, 255));
  endfunction

  // short gaps let countdowns run down, long ones force expiry
  function automatic logic [15:0] rand_elapsed();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(0, 300));
      1:       return 16'($urandom_range(0, 5000));
      2:       return 16'($urandom_range(0, 65535));
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // present one command beat, with random gaps ahead of it, and wait for acceptance
  // valid stays high into the next call so back-to-back beats leave no gap
  task automatic send_cmd(cmd_beat_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= c.action;
    in_ch.motor <= c.motor;
    in_ch.speed <= c.speed;
    in_ch.steps <= c.steps;
    in_ch.elapsed_us <= c.elapsed;
    do begin
      @(posedge clk);
    end while (in_ch.ready !== 1'b1);
    sb.note_cmd(c);
  endtask

  // stop sending and let every pending result beat come back, then idle a little
  task automatic wait_drained(int settle);
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // write all eight delay registers back to back, only while the block is idle
  task automatic load_delays(logic [15:0] vals [DELAY_REGS]);
    for (int i = 0; i < DELAY_REGS; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= 3'(i);
      cfg_ch.data <= vals[i];
      do begin
        @(posedge clk);
      end while (cfg_ch.ready !== 1'b1);
      sb.set_delay(i, vals[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly well-formed moves: power, a command or two, a run of ticks;
  // the rest fully random beats including bad motors and unused actions
  task automatic run_random(int n);
    int  sent;
    bit  paused;
    sent = 0;
    paused = 1'b0;
    while (sent < n) begin
      // once per phase hold the sender until the pipe is empty
      if (!paused && sent >= n / 2) begin
        wait_drained(0);
        paused = 1'b1;
      end
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(99) < 20) begin
          send_cmd(beat_of(tass_pkg::ACT_POWER_ON, 2'($urandom_range(0, 3)), rand_speed(),
                           14'($urandom_range(0, 16383)), rand_elapsed()));
          sent++;
        end
        repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(99) < 60)
            send_cmd(beat_of(tass_pkg::ACT_STEP_MOVE, 2'($urandom_range(0, 2)),
                             rand_speed(),
                             ($urandom_range(99) < 85) ? 14'($urandom_range(0, 25))
                                                       : 14'($urandom_range(0, 16383)),
                             rand_elapsed()));
          else
            send_cmd(beat_of(tass_pkg::ACT_SET_SPEED, 2'($urandom_range(0, 2)),
                             rand_speed(), 14'($urandom_range(0, 16383)),
                             rand_elapsed()));
          sent++;
        end
        repeat ($urandom_range(2, 10)) begin
          send_cmd(beat_of(tass_pkg::ACT_TICK, 2'($urandom_range(0, 3)),
                           8'($urandom_range(0, 255)),
                           14'($urandom_range(0, 16383)), rand_elapsed()));
          sent++;
        end
        if ($urandom_range(99) < 5) begin
          send_cmd(beat_of(tass_pkg::ACT_POWER_OFF, 2'($urandom_range(0, 3)), rand_speed(),
                           14'($urandom_range(0, 16383)), rand_elapsed()));
          sent++;
        end
      end else begin
        send_cmd(beat_of(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)), 14'($urandom_range(0, 16383)),
                         16'($urandom_range(0, 65535))));
        sent++;
      end
    end
  endtask

  // result side: check each accepted beat, then pick next cycle's ready
  initial begin
    tass_pkg::result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.coils_pan = out_ch.coils_pan;
        got.coils_tilt = out_ch.coils_tilt;
        got.coils_rotate = out_ch.coils_rotate;
        got.pos_pan = out_ch.pos_pan;
        got.pos_tilt = out_ch.pos_tilt;
        got.pos_rotate = out_ch.pos_rotate;
        got.move_done = out_ch.move_done;
        sb.check_state(got);
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog, far above the slowest correct run
  initial begin
    #2ms;
    $display("tb_three_axis_stepper_sequencer: FAIL");
    $finish;
  end

  initial begin
    logic [15:0] vals [DELAY_REGS];
    src_idle_pct = 0;
    sink_stall_pct = 0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.action <= tass_pkg::ACT_TICK;
    in_ch.motor <= AXIS_PAN;
    in_ch.speed <= '0;
    in_ch.steps <= '0;
    in_ch.elapsed_us <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset delays
    // tick while unpowered and all countdowns at zero: idle expiry, coils stay low
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'h0000));
    // power on ignores the motor field, even an out of range one
    send_cmd(beat_of(tass_pkg::ACT_POWER_ON, AXIS_BAD, 8'sd0, 14'd0, 16'h0000));
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'hFFFF));
    // speeds beyond the range saturate to +7 / -7
    send_cmd(beat_of(tass_pkg::ACT_SET_SPEED, AXIS_PAN, 8'sd99, 14'd0, 16'h0000));
    send_cmd(beat_of(tass_pkg::ACT_SET_SPEED, AXIS_TILT, -8'sd99, 14'd0, 16'h0000));
    send_cmd(beat_of(tass_pkg::ACT_STEP_MOVE, AXIS_ROTATE, 8'sd3, 14'd2, 16'h0000));
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'hFFFF));
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'h0000));
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'h0001));
    // rotate runs out of its two-step budget here
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'hFFFF));
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'hFFFF));
    // speed zero request: pan stops after its next step
    send_cmd(beat_of(tass_pkg::ACT_SET_SPEED, AXIS_PAN, 8'sd0, 14'd0, 16'h0000));
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'hFFFF));
    // step move at speed zero keeps the motor still, budget stored
    send_cmd(beat_of(tass_pkg::ACT_STEP_MOVE, AXIS_TILT, 8'sd0, 14'd5, 16'h0000));
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'hFFFF));
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'hFFFF));
    // bad motor: both commands do nothing
    send_cmd(beat_of(tass_pkg::ACT_SET_SPEED, AXIS_BAD, 8'sd5, 14'd0, 16'h0000));
    send_cmd(beat_of(tass_pkg::ACT_STEP_MOVE, AXIS_BAD, -8'sd5, 14'd9999, 16'h0000));
    // unused action codes change nothing, every other field at all ones
    for (int a = int'(tass_pkg::ACT_POWER_OFF) + 1; a < (1 << $bits(tass_pkg::action_t));
         a++)
      send_cmd(beat_of(3'(a), AXIS_BAD, -8'sd1, 14'h3FFF, 16'hFFFF));
    // tilt starts with the stored budget of five
    send_cmd(beat_of(tass_pkg::ACT_SET_SPEED, AXIS_TILT, -8'sd128, 14'd0, 16'h0000));
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'hFFFF));
    send_cmd(beat_of(tass_pkg::ACT_STEP_MOVE, AXIS_PAN, 8'sd127, 14'h3FFF, 16'h0000));
    // power off: coils read zero and the latch is written low on expiry
    send_cmd(beat_of(tass_pkg::ACT_POWER_OFF, AXIS_ROTATE, 8'sd0, 14'd0, 16'h0000));
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'hFFFF));
    send_cmd(beat_of(tass_pkg::ACT_POWER_ON, AXIS_PAN, 8'sd0, 14'd0, 16'h0000));
    send_cmd(beat_of(tass_pkg::ACT_TICK, AXIS_PAN, 8'sd0, 14'd0, 16'hFFFF));
    wait_drained(4);

    // random phases, each with its own delay set and one of four idling modes
    for (int p = 0; p < 5; p++) begin
      foreach (vals[i]) begin
        case (p)
          0:       vals[i] = 16'($urandom_range(1, 400));
          1:       vals[i] = 16'h0000;
          2:       vals[i] = 16'hFFFF;
          3:       vals[i] = 16'($urandom_range(0, 65535));
          default: vals[i] = (i == 0) ? 16'h0000 : 16'($urandom_range(0, 3000));
        endcase
      end
      load_delays(vals);
      case (p % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 63;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 63;
        end
        default: begin
          src_idle_pct = 11;
          sink_stall_pct = 11;
        end
      endcase
      run_random(160);
      wait_drained(4);
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_three_axis_stepper_sequencer: PASS");
    else
      $display("tb_three_axis_stepper_sequencer: FAIL");
    $finish;
  end

endmodule
